@@ design/double_ended_queue_defines.svh @@
// Assertion macros for the deque RTL, used by deq_ctrl.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DQ_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("deque check failed");
`define DQ_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |=> (effect)) \
        else $error("deque sequence check failed");
`else
`define DQ_ASSERT(label, expr)
`define DQ_ASSERT_NEXT(label, cause, effect)
`endif
`endif

@@ design/dq_pkg.sv @@
// Types, constants and helpers for the double-ended queue.
`default_nettype none
package dq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 72;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        status_t            status;
    } dq_result_t;

    // (head + off) mod DEPTH, valid for head < DEPTH and off <= DEPTH
    function automatic addr_t wrap_add(input addr_t head, input cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage
`default_nettype wire

@@ design/deq_ram.sv @@
// Slot memory: one write port, two registered read ports.
`default_nettype none
module deq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    localparam int AW = $clog2(DEPTH_P)
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [WIDTH_P-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr_a,
    input  wire logic [AW-1:0]      rd_addr_b,
    output logic      [WIDTH_P-1:0] rd_data_a,
    output logic      [WIDTH_P-1:0] rd_data_b
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
`default_nettype wire

@@ design/deq_ctrl.sv @@
// Head/count update, slot memory access and result assembly.
`default_nettype none
`include "double_ended_queue_defines.svh"
module deq_ctrl
    import dq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mode_t       in_mode,
    input  wire data_t       in_value,
    output logic             res_valid,
    input  wire logic        res_ready,
    output dq_result_t       res
);

    state_t  state_reg, state_next;
    addr_t   head_reg, head_next;
    cnt_t    cnt_reg, cnt_next;
    status_t status_reg, status_next;
    logic    fwd_front_reg, fwd_front_next;
    logic    fwd_back_reg, fwd_back_next;
    data_t   fwd_data_reg;

    logic    accept;
    logic    full, empty;
    logic    wr_en;
    addr_t   wr_addr;
    addr_t   head_dec, head_inc;
    addr_t   rd_addr_b;
    data_t   rd_data_a, rd_data_b;
    data_t   front_data, back_data;

    assign accept   = in_valid && in_ready;
    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        status_next = STATUS_OK;
        wr_en       = 1'b0;
        wr_addr     = head_dec;
        unique case (in_mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    wr_en     = accept;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            MODE_PUSH_BACK: begin
                wr_addr = wrap_add(head_reg, cnt_reg);
                if (full) begin
                    status_next = STATUS_OVERFLOW;
                end else begin
                    wr_en    = accept;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    status_next = STATUS_UNDERFLOW;
                end else begin
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    status_next = STATUS_UNDERFLOW;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                status_next = STATUS_OK;
            end
        endcase
    end

    assign rd_addr_b = (cnt_next == '0) ? head_next : wrap_add(head_next, cnt_next - 1'b1);

    // the pushed element lands on the front or back address read in the same cycle
    assign fwd_front_next = wr_en && (in_mode == MODE_PUSH_FRONT || cnt_next == CNT_W'(1));
    assign fwd_back_next  = wr_en && (in_mode == MODE_PUSH_BACK || cnt_next == CNT_W'(1));

    deq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_WIDTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (in_value),
        .rd_en     (accept),
        .rd_addr_a (head_next),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_RESULT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            status_reg    <= STATUS_OK;
            fwd_front_reg <= 1'b0;
            fwd_back_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                head_reg      <= head_next;
                cnt_reg       <= cnt_next;
                status_reg    <= status_next;
                fwd_front_reg <= fwd_front_next;
                fwd_back_reg  <= fwd_back_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fwd_data_reg <= in_value;
        end
    end

    assign front_data = fwd_front_reg ? fwd_data_reg : rd_data_a;
    assign back_data  = fwd_back_reg  ? fwd_data_reg : rd_data_b;

    always_comb begin
        res.front_value = empty ? '0 : VALUE_W'(front_data);
        res.back_value  = empty ? '0 : VALUE_W'(back_data);
        res.count       = COUNT_W'(cnt_reg);
        res.empty_res   = empty;
        res.status      = status_reg;
    end

    `DQ_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(DEPTH))
    `DQ_ASSERT_NEXT(a_accept_to_result, accept, state_reg == S_RESULT)
    `DQ_ASSERT(a_overflow_full, !res_valid || status_reg != STATUS_OVERFLOW || full)
    `DQ_ASSERT(a_underflow_empty, !res_valid || status_reg != STATUS_UNDERFLOW || empty)
    `DQ_ASSERT_NEXT(a_state_frozen, state_reg == S_RESULT, $stable(cnt_reg) && $stable(head_reg))

endmodule
`default_nettype wire

@@ design/deq_out.sv @@
// Output register for the result channel.
`default_nettype none
module deq_out
    import dq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   res_valid,
    output logic                        res_ready,
    input  wire dq_result_t             res,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic       valid_reg;
    dq_result_t data_reg;

    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.status, data_reg.empty_res, data_reg.count,
                       data_reg.back_value, data_reg.front_value};

endmodule
`default_nettype wire

@@ design/double_ended_queue.sv @@
// Top level of the fixed-capacity double-ended queue.
//
//   channel  dir  tdata fields (low bit up)
//   s_       in   mode[1:0], value[33:2], zero pad [39:34]
//   m_       out  front_value[31:0], back_value[63:32], count[68:64],
//                 empty_res[69], status[71:70]
//
// Each item first updates head/count, writes the slot and issues both reads;
// then the registered read data reaches the output.
// The slot memory is not cleared at reset; head, count, status and state reset.
// With m_tready low, one result waits in the output register and one more
// item is taken, after which s_tready stays low.
`default_nettype none
module double_ended_queue
    import dq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // mode, value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_TDATA_W-1:0]     m_tdata    // front_value, back_value, count, empty_res, status
);

    mode_t      in_mode;
    data_t      in_value;
    logic       res_valid;
    logic       res_ready;
    dq_result_t res;

    assign in_mode  = mode_t'(s_tdata[1:0]);
    assign in_value = data_t'(s_tdata[VALUE_W+1:2]);

    deq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (in_mode),
        .in_value  (in_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    deq_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
